@@ hdl/vwcp_pkg.sv @@
package vwcp_pkg;

    // Field widths of the ports
    localparam int CODE_W          = 16;
    localparam int CODE_WIDTH_W    = 5;
    localparam int BYTE_W          = 8;

    // Packing limits
    localparam int MIN_CODE_WIDTH  = 8;
    localparam int MAX_CODE_WIDTH  = 16;
    localparam int PEND_W          = 7;

    localparam logic [CODE_W-1:0] END_CODE_RESET = 16'd256;

    // Control handed from the input stage to the serializer
    typedef struct packed {
        logic valid;
        logic is_end;
    } ctl_t;

endpackage

@@ hdl/vwcp_in_stage.sv @@
module vwcp_in_stage #(
    parameter int MAX_CODE_WIDTH = vwcp_pkg::MAX_CODE_WIDTH,
    parameter int WW             = $clog2(MAX_CODE_WIDTH + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [vwcp_pkg::CODE_W-1:0]       cfg_end_code,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [vwcp_pkg::CODE_W-1:0]       s_code,
    input  logic [vwcp_pkg::CODE_WIDTH_W-1:0] s_code_width,
    input  logic                              take,
    output vwcp_pkg::ctl_t                    ctl,
    output logic [MAX_CODE_WIDTH-1:0]         code_al,
    output logic [WW-1:0]                     width
);
    import vwcp_pkg::*;

    localparam int CW_EXT = (MAX_CODE_WIDTH > CODE_W) ? MAX_CODE_WIDTH : CODE_W;

    logic [CODE_W-1:0]         end_code_reg;
    logic                      valid_reg, valid_next;
    logic                      is_end_reg;
    logic [MAX_CODE_WIDTH-1:0] code_al_reg;
    logic [WW-1:0]             width_reg;

    logic [WW-1:0]             w_cl;
    logic [CW_EXT-1:0]         code_wide;
    logic [MAX_CODE_WIDTH-1:0] code_al_next;
    logic                      s_fire;

    assign s_ready = !valid_reg || take;
    assign s_fire  = s_valid && s_ready;

    // Clamp the width into range, keep only its low bits of the code,
    // and left-align the code so the serializer only shifts by the pending count
    always_comb begin
        if (s_code_width < CODE_WIDTH_W'(MIN_CODE_WIDTH)) begin
            w_cl = WW'(MIN_CODE_WIDTH);
        end else if (s_code_width > CODE_WIDTH_W'(MAX_CODE_WIDTH)) begin
            w_cl = WW'(MAX_CODE_WIDTH);
        end else begin
            w_cl = WW'(s_code_width);
        end
        code_wide    = CW_EXT'(s_code) & ((CW_EXT'(1) << w_cl) - CW_EXT'(1));
        code_al_next = code_wide[MAX_CODE_WIDTH-1:0] << (WW'(MAX_CODE_WIDTH) - w_cl);
    end

    always_comb begin
        valid_next = valid_reg;
        if (s_fire) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            end_code_reg <= END_CODE_RESET;
        end else begin
            valid_reg <= valid_next;
            if (cfg_valid) begin
                end_code_reg <= cfg_end_code;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            is_end_reg  <= (s_code == end_code_reg);
            code_al_reg <= code_al_next;
            width_reg   <= w_cl;
        end
    end

    assign ctl.valid  = valid_reg;
    assign ctl.is_end = is_end_reg;
    assign code_al    = code_al_reg;
    assign width      = width_reg;

endmodule

@@ hdl/vwcp_serializer.sv @@
module vwcp_serializer #(
    parameter int MAX_CODE_WIDTH = vwcp_pkg::MAX_CODE_WIDTH,
    parameter int WW             = $clog2(MAX_CODE_WIDTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  vwcp_pkg::ctl_t              ctl,
    input  logic [MAX_CODE_WIDTH-1:0]   code_al,
    input  logic [WW-1:0]               width,
    output logic                        take,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [vwcp_pkg::BYTE_W-1:0] m_out_byte,
    output logic                        m_last
);
    import vwcp_pkg::*;

    localparam int MAX_RES = (2 * PEND_W + MAX_CODE_WIDTH) / BYTE_W;
    localparam int BUF_W   = BYTE_W * MAX_RES;
    localparam int NB_W    = $clog2(MAX_RES + 1);
    localparam int TW      = $clog2(PEND_W + MAX_CODE_WIDTH + 1);
    localparam int PC_W    = $clog2(PEND_W + 1);

    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [NB_W-1:0]   nbytes_reg, nbytes_next;
    logic              last_reg, last_next;
    logic [PEND_W-1:0] pend_bits_reg, pend_bits_next;
    logic [PC_W-1:0]   pend_count_reg, pend_count_next;

    logic [BUF_W-1:0]  buf_new, rest;
    logic [TW-1:0]     total;
    logic [TW-4:0]     full_bytes;
    logic [2:0]        rem;
    logic              pad;

    assign m_valid    = (nbytes_reg != '0);
    assign m_out_byte = buf_reg[BUF_W-1 -: BYTE_W];
    assign m_last     = last_reg && (nbytes_reg == NB_W'(1));
    assign take       = ctl.valid
                      && ((nbytes_reg == '0) || ((nbytes_reg == NB_W'(1)) && m_ready));

    // Pending bits sit left-aligned on top, the new code right behind them
    always_comb begin
        buf_new    = {pend_bits_reg, {(BUF_W-PEND_W){1'b0}}}
                   | ({code_al, {(BUF_W-MAX_CODE_WIDTH){1'b0}}} >> pend_count_reg);
        total      = TW'(pend_count_reg) + TW'(width);
        full_bytes = total[TW-1:3];
        rem        = total[2:0];
        pad        = ctl.is_end && (rem != 3'd0);
        rest       = buf_new << {full_bytes, 3'b000};
    end

    always_comb begin
        buf_next        = buf_reg;
        nbytes_next     = nbytes_reg;
        last_next       = last_reg;
        pend_bits_next  = pend_bits_reg;
        pend_count_next = pend_count_reg;
        if (take) begin
            buf_next    = buf_new;
            nbytes_next = NB_W'(full_bytes) + NB_W'(pad);
            last_next   = ctl.is_end;
            if (ctl.is_end) begin
                pend_bits_next  = '0;
                pend_count_next = '0;
            end else begin
                pend_bits_next  = rest[BUF_W-1 -: PEND_W];
                pend_count_next = PC_W'(rem);
            end
        end else if (m_valid && m_ready) begin
            buf_next    = buf_reg << BYTE_W;
            nbytes_next = nbytes_reg - NB_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nbytes_reg     <= '0;
            last_reg       <= 1'b0;
            pend_bits_reg  <= '0;
            pend_count_reg <= '0;
        end else begin
            nbytes_reg     <= nbytes_next;
            last_reg       <= last_next;
            pend_bits_reg  <= pend_bits_next;
            pend_count_reg <= pend_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

endmodule

@@ hdl/variable_width_code_packer.sv @@
// Variable-width code packer, MSB first.
//
// Input channel (s_valid/s_ready): one code per transfer, s_code with its
// width s_code_width (8 up to MAX_CODE_WIDTH; values outside are clamped).
// Output channel (m_valid/m_ready): one packed byte per transfer, the
// earliest bit in bit 7. m_last marks the final byte of an end code.
// Config channel (cfg_valid/cfg_ready): writes the end code; cfg_ready is
// always high. Write it only while the block is idle.
//
// Path: a code is held in the input register, then in the result register that drives m_out_byte.
// Throughput: one byte per cycle on the output while m_ready is high; a
// code yielding N bytes (2 or 3 at width 16) occupies the output register
// until all N have gone out, so the code rate is set by the byte serializer.
// A new code is taken while the last byte of the previous one goes out.
//
// Reset (aresetn low, synchronous) drops any held code and bytes, clears
// the leftover bits and restores the end code to 256.
// When the receiver stalls, the byte and m_last hold; one code waits in the
// input register and s_ready drops until the serializer takes it.
module variable_width_code_packer #(
    parameter int MAX_CODE_WIDTH = vwcp_pkg::MAX_CODE_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vwcp_pkg::CODE_W-1:0]       cfg_end_code,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [vwcp_pkg::CODE_W-1:0]       s_code,
    input  logic [vwcp_pkg::CODE_WIDTH_W-1:0] s_code_width,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [vwcp_pkg::BYTE_W-1:0]       m_out_byte,
    output logic                              m_last
);
    import vwcp_pkg::*;

    localparam int WW = $clog2(MAX_CODE_WIDTH + 1);

    ctl_t                      ctl;
    logic [MAX_CODE_WIDTH-1:0] code_al;
    logic [WW-1:0]             width;
    logic                      take;

    // Config writes are registered, never stall
    assign cfg_ready = 1'b1;

    // Input register: clamp, mask, align, compare against the end code
    vwcp_in_stage #(
        .MAX_CODE_WIDTH(MAX_CODE_WIDTH),
        .WW            (WW)
    ) u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_end_code(cfg_end_code),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code      (s_code),
        .s_code_width(s_code_width),
        .take        (take),
        .ctl         (ctl),
        .code_al     (code_al),
        .width       (width)
    );

    // Result register: merge with leftover bits, hand out one byte per transfer
    vwcp_serializer #(
        .MAX_CODE_WIDTH(MAX_CODE_WIDTH),
        .WW            (WW)
    ) u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .code_al   (code_al),
        .width     (width),
        .take      (take),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_byte(m_out_byte),
        .m_last    (m_last)
    );

endmodule

@@ hdl/vwcp_checker.sv @@
module vwcp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       cfg_ready,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_last
);

    // Hold a stalled byte and its last flag
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last))
        else $error("output changed while stalled");

    // Synchronous reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    // Once a code transfer has passed the input and result registers, the output register is not empty
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##2 m_valid)
        else $error("accepted code produced no byte in time");

    // With nothing on the output the input side never blocks
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready && cfg_ready)
        else $error("input blocked while output empty");

endmodule

bind variable_width_code_packer vwcp_checker u_vwcp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_ready (cfg_ready),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_out_byte(m_out_byte),
    .m_last    (m_last)
);

@@ tb/sv/variable_width_code_packer_tb.sv @@
`timescale 1ns / 1ps

module variable_width_code_packer_tb;
    import vwcp_pkg::*;

    // One packed byte as it should leave the block
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } packed_byte_t;

    // One row of the directed table. An optional end-code write comes first.
    // Rows with n_known > 0 carry their bytes typed in; the rest go to the predictor.
    typedef struct packed {
        bit                     wr_end;
        logic [CODE_W-1:0]      end_val;
        logic [CODE_W-1:0]      code;
        logic [CODE_WIDTH_W-1:0] width;
        int                     n_known;
        logic [0:2][BYTE_W-1:0] known_bytes;
        logic [0:2]             known_last;
    } code_row_t;

    localparam int N_ROWS = 21;

    // Rows 1..8 start from empty leftover, so their bytes can be read off directly.
    localparam code_row_t DIRECTED [N_ROWS] = '{
        '{0, 16'h0000, 16'h00A5, 5'd8,  1, {8'hA5, 8'h00, 8'h00}, 3'b000},
        '{0, 16'h0000, 16'hFFFF, 5'd16, 2, {8'hFF, 8'hFF, 8'h00}, 3'b000},
        '{0, 16'h0000, 16'h0000, 5'd16, 2, {8'h00, 8'h00, 8'h00}, 3'b000},
        // reset end code, no leftover: no pad, last on the second byte
        '{0, 16'h0000, 16'h0100, 5'd16, 2, {8'h01, 8'h00, 8'h00}, 3'b010},
        // width below range, code wider than its width
        '{0, 16'h0000, 16'hFFFF, 5'd0,  1, {8'hFF, 8'h00, 8'h00}, 3'b000},
        // width above range
        '{0, 16'h0000, 16'h1234, 5'd31, 2, {8'h12, 8'h34, 8'h00}, 3'b000},
        '{0, 16'h0000, 16'h0100, 5'd8,  1, {8'h00, 8'h00, 8'h00}, 3'b100},
        // low bits equal those of the end code but the full code does not
        '{0, 16'h0000, 16'h1100, 5'd8,  1, {8'h00, 8'h00, 8'h00}, 3'b000},
        '{0, 16'h0000, 16'hFF00, 5'd9,  0, '0, '0},
        '{0, 16'h0000, 16'h7FFF, 5'd15, 0, '0, '0},
        '{0, 16'h0000, 16'h0003, 5'd10, 0, '0, '0},
        // end code with leftover: padded final byte
        '{0, 16'h0000, 16'h0100, 5'd11, 0, '0, '0},
        '{1, 16'h0000, 16'h0000, 5'd12, 0, '0, '0},
        '{0, 16'h0000, 16'hFF00, 5'd8,  0, '0, '0},
        '{0, 16'h0000, 16'h0000, 5'd8,  1, {8'h00, 8'h00, 8'h00}, 3'b100},
        '{1, 16'hFFFF, 16'hFFFF, 5'd16, 2, {8'hFF, 8'hFF, 8'h00}, 3'b010},
        '{0, 16'h0000, 16'hABCD, 5'd13, 0, '0, '0},
        '{0, 16'h0000, 16'h5555, 5'd17, 0, '0, '0},
        '{0, 16'h0000, 16'hFFFF, 5'd7,  0, '0, '0},
        '{0, 16'h0000, 16'h8001, 5'd16, 0, '0, '0},
        // end code on top of five leftover bits: two bytes and a padded third
        '{1, 16'h0100, 16'h0100, 5'd16, 0, '0, '0}
    };

    localparam int N_PHASES        = 7;
    localparam int CODES_PER_PHASE = 50;
    localparam int SETTLE_CYCLES   = 4;

    logic                    aclk         = 1'b0;
    logic                    aresetn      = 1'b0;
    logic                    cfg_valid    = 1'b0;
    logic                    cfg_ready;
    logic [CODE_W-1:0]       cfg_end_code = '0;
    logic                    s_valid      = 1'b0;
    logic                    s_ready;
    logic [CODE_W-1:0]       s_code       = '0;
    logic [CODE_WIDTH_W-1:0] s_code_width = '0;
    logic                    m_valid;
    logic                    m_ready      = 1'b0;
    logic [BYTE_W-1:0]       m_out_byte;
    logic                    m_last;

    // Predictor state: end code in force and the bits not yet forming a byte
    logic [CODE_W-1:0] end_code_q = END_CODE_RESET;
    logic [PEND_W-1:0] leftover_bits = '0;
    logic [2:0]        leftover_cnt = '0;

    packed_byte_t bytes_due[$];
    int           mismatches = 0;
    bit           no_idle = 1'b0;

    variable_width_code_packer u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_end_code (cfg_end_code),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_code       (s_code),
        .s_code_width (s_code_width),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_last       (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Append one code to the leftover bits and cut off every full byte, MSB first.
    // Flush a zero-padded byte on the end code and mark the final byte last.
    function automatic int pack_code(input logic [CODE_W-1:0] code,
                                     input logic [CODE_WIDTH_W-1:0] width_in,
                                     output logic [0:2][BYTE_W-1:0] bytes,
                                     output logic [0:2] lasts);
        int          w;
        int          total;
        int          n;
        logic [31:0] acc;
        logic        is_end;
        w = int'(width_in);
        if (w < MIN_CODE_WIDTH) w = MIN_CODE_WIDTH;
        if (w > MAX_CODE_WIDTH) w = MAX_CODE_WIDTH;
        acc = ({25'd0, leftover_bits} << w) | ({16'd0, code} & ((32'd1 << w) - 32'd1));
        total = int'(leftover_cnt) + w;
        n = 0;
        bytes = '0;
        lasts = '0;
        while (total >= 8) begin
            bytes[n] = BYTE_W'(acc >> (total - 8));
            n++;
            total -= 8;
        end
        is_end = (code == end_code_q);
        if (is_end && total > 0) begin
            bytes[n] = BYTE_W'(acc << (8 - total));
            n++;
            total = 0;
        end
        if (is_end && n > 0) lasts[n-1] = 1'b1;
        leftover_cnt = 3'(total);
        leftover_bits = PEND_W'(acc & ((32'd1 << total) - 32'd1));
        return n;
    endfunction

    // Present one code after a random gap (none when no_idle is set), hold it until the transfer, then
    // queue the bytes it must produce. Leave s_valid high: the caller either
    // sends the next code or drops valid in this same step.
    task automatic send_code(input logic [CODE_W-1:0] code,
                             input logic [CODE_WIDTH_W-1:0] width,
                             input int n_known,
                             input logic [0:2][BYTE_W-1:0] known_bytes,
                             input logic [0:2] known_last);
        int                     gap;
        int                     n;
        logic [0:2][BYTE_W-1:0] pbytes;
        logic [0:2]             plast;
        packed_byte_t           b;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_code       <= code;
        s_code_width <= width;
        do @(posedge aclk); while (!(s_valid && s_ready));
        // Advance the predictor on every code, typed rows included
        n = pack_code(code, width, pbytes, plast);
        if (n_known > 0) begin
            n = n_known;
            pbytes = known_bytes;
            plast = known_last;
        end
        for (int k = 0; k < n; k++) begin
            b.data = pbytes[k];
            b.last = plast[k];
            bytes_due.push_back(b);
        end
    endtask

    // Drop valid and hold off until every queued byte has come out
    task automatic drain_output();
        s_valid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge aclk);
    endtask

    // Write the end code only with the block idle, past its pipeline latency
    task automatic set_end_code(input logic [CODE_W-1:0] value);
        drain_output();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid    <= 1'b1;
        cfg_end_code <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid  <= 1'b0;
        end_code_q = value;
    endtask

    // Byte receiver: stall a random number of cycles (none when no_idle is set) before each transfer,
    // then compare the byte against the oldest one queued.
    initial begin : byte_sink
        int           gap;
        packed_byte_t want;
        wait (aresetn === 1'b1);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            if (bytes_due.size() == 0) begin
                $error("unexpected byte: out_byte %h, last %b", m_out_byte, m_last);
                mismatches++;
            end else begin
                want = bytes_due.pop_front();
                if (m_out_byte !== want.data) begin
                    $error("out_byte: expected %h, actual %h", want.data, m_out_byte);
                    mismatches++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, m_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [CODE_W-1:0]       end_val;
        logic [CODE_W-1:0]       code;
        logic [CODE_WIDTH_W-1:0] width;
        int                      spins;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table: extremes, clamped widths, end-code cases
        for (int i = 0; i < N_ROWS; i++) begin
            if (DIRECTED[i].wr_end) set_end_code(DIRECTED[i].end_val);
            send_code(DIRECTED[i].code, DIRECTED[i].width, DIRECTED[i].n_known,
                      DIRECTED[i].known_bytes, DIRECTED[i].known_last);
        end

        // Random phases, each under its own end code; every third runs without gaps
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    end_val = '0;
                end
                1: begin
                    end_val = '1;
                end
                default: begin
                    end_val = CODE_W'($urandom_range(0, 65535));
                end
            endcase
            set_end_code(end_val);
            no_idle = (ph % 3 == 2);
            for (int k = 0; k < CODES_PER_PHASE; k++) begin
                // Hit the end code often so flushes land at every leftover count
                if ($urandom_range(0, 99) < 15) code = end_code_q;
                else code = CODE_W'($urandom());
                if ($urandom_range(0, 99) < 85) width = CODE_WIDTH_W'($urandom_range(8, 16));
                else width = CODE_WIDTH_W'($urandom_range(0, 31));
                send_code(code, width, 0, '0, '0);
                if ($urandom_range(0, 39) == 0) drain_output();
            end
        end
        no_idle = 1'b0;

        // Let the tail drain, then keep watching for stray bytes
        s_valid <= 1'b0;
        spins = 0;
        while (bytes_due.size() != 0 && spins < 5000) begin
            @(posedge aclk);
            spins++;
        end
        if (bytes_due.size() != 0) begin
            $error("%0d expected bytes never arrived", bytes_due.size());
            mismatches++;
        end
        repeat (8) @(posedge aclk);

        if (mismatches == 0) begin
            $display("variable_width_code_packer regression: pass");
        end else begin
            $display("variable_width_code_packer regression: fail");
        end
        $finish;
    end

    // Watchdog: far past the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("variable_width_code_packer regression: fail");
        $finish;
    end

endmodule
